// ===== rtl/bbg_pkg.sv =====
// Shared types, constants and codes for the Brownian bridge generator.
package bbg_pkg;

  localparam int unsigned CHANNELS_DEF = 16;

  localparam logic [31:0] PERIOD_RST = 32'd89478;
  localparam logic [31:0] NSCALE_RST = 32'd19604207;
  localparam logic [31:0] THIGH_RST  = 32'h0100_0000;
  localparam logic [31:0] TLOW_RST   = 32'h0000_0000;

  localparam logic [7:0] CFG_SAMPLE_PERIOD = 8'd0;
  localparam logic [7:0] CFG_NOISE_SCALE   = 8'd1;
  localparam logic [7:0] CFG_TRIGGER_HIGH  = 8'd2;
  localparam logic [7:0] CFG_TRIGGER_LOW   = 8'd3;

  localparam int unsigned QUOT_W = 35;
  localparam logic [QUOT_W-1:0] DRIFT_CAP = QUOT_W'(64'd1 << 34);

  typedef struct packed {
    logic [3:0]         channel;
    logic signed [31:0] trigger_level;
    logic signed [31:0] range;
    logic signed [31:0] offset;
    logic signed [31:0] noise_level;
    logic signed [47:0] duration;
    logic signed [15:0] gauss_sample;
  } bbg_in_t;

  typedef struct packed {
    logic [3:0]         channel_out;
    logic signed [31:0] signal;
  } bbg_out_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic signed [47:0] elapsed;
    logic signed [47:0] dur;
    logic               trig;
  } bbg_state_t;

  typedef struct packed {
    logic [31:0] sample_period;
    logic [31:0] noise_scale;
    logic [31:0] trigger_high;
    logic [31:0] trigger_low;
  } bbg_cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_READ, OP_PREP, OP_GS, OP_STEP, OP_DIFF,
    OP_MULH, OP_MULL, OP_DIVI, OP_DIV, OP_FIN
  } bbg_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_PREP, ST_GS, ST_STEP, ST_DIFF, ST_MULH, ST_MULL,
    ST_DIVI, ST_DIV, ST_FIN
  } bbg_state_e;

  typedef struct packed {
    bbg_op_e op;
  } bbg_cmd_t;

  typedef struct packed {
    logic active;
    logic div_last;
    logic out_free;
  } bbg_stat_t;

endpackage

// ===== rtl/bbg_ctrl.sv =====
// Sequencer that walks one tick through the datapath.
module bbg_ctrl import bbg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      busy_o,
  input  bbg_stat_t stat_i,
  output bbg_cmd_t  cmd_o
);

  bbg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.op = OP_READ;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.op = OP_PREP;
        state_d = ST_GS;
      end
      ST_GS: begin
        // endpoint ticks skip the noise and drift path
        if (stat_i.active) begin
          cmd_o.op = OP_GS;
          state_d = ST_STEP;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_STEP: begin
        cmd_o.op = OP_STEP;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d = ST_MULH;
      end
      ST_MULH: begin
        cmd_o.op = OP_MULH;
        state_d = ST_MULL;
      end
      ST_MULL: begin
        cmd_o.op = OP_MULL;
        state_d = ST_DIVI;
      end
      ST_DIVI: begin
        cmd_o.op = OP_DIVI;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (stat_i.div_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the beat
        if (stat_i.out_free) begin
          cmd_o.op = OP_FIN;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/bbg_dp.sv =====
// Datapath: channel state memory, multipliers, serial divider, output register.
module bbg_dp import bbg_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bbg_cmd_t  cmd_i,
  output bbg_stat_t stat_o,
  input  bbg_cfg_t  cfg_i,
  input  bbg_in_t   in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output bbg_out_t  out_o
);

  localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [IW-1:0] idx_tbl [16];
  for (genvar i = 0; i < 16; i++) begin : g_tbl
    assign idx_tbl[i] = IW'(i % CHANNELS);
  end

  bbg_state_t mem_q [CHANNELS];
  logic [CHANNELS-1:0] vld_q;
  bbg_state_t rd_q;
  logic rdv_q;

  bbg_in_t in_q;
  logic [IW-1:0] idx_q;

  logic               trig_q, active_q, neg_q, ovf_q;
  logic signed [47:0] el_q;
  logic [47:0]        rem_q;
  logic signed [31:0] out1_q, nr_q, v1_q;
  logic signed [28:0] gs_q;
  logic signed [44:0] step_q;
  logic [33:0]        mag_q;
  logic [49:0]        ph_q;
  logic [65:0]        p_q;
  logic [34:0]        dl_q;
  logic [47:0]        r_q;
  logic [QUOT_W-1:0]  quot_q;
  logic [5:0]         cnt_q;
  logic               out_valid_q;
  bbg_out_t           out_q;

  // prep stage
  bbg_state_t         st;
  logic               new_trig, rising, restart;
  logic signed [47:0] base_el, el_n, dur;
  logic signed [48:0] el_sum;
  logic signed [52:0] d53, dur17;
  logic signed [48:0] thr;
  logic signed [63:0] nr_prod;
  logic signed [48:0] gs_prod;
  logic signed [60:0] st_prod;
  logic signed [45:0] sum46;
  logic signed [31:0] v1;
  logic signed [33:0] diff;
  logic [47:0]        r2;
  logic               ge;
  logic [QUOT_W-1:0]  q;
  logic signed [36:0] vfin;
  logic signed [31:0] vsat;

  // divider setup is flagged on entry to the divide state
  logic div_init_q;

  always_comb begin
    st = rdv_q ? rd_q : '0;
    dur = in_q.duration;
    new_trig = st.trig;
    rising = 1'b0;
    if (st.trig) begin
      if (in_q.trigger_level <= $signed(cfg_i.trigger_low)) new_trig = 1'b0;
    end else if (in_q.trigger_level >= $signed(cfg_i.trigger_high)) begin
      new_trig = 1'b1;
      rising = 1'b1;
    end
    restart = rising || (dur != st.dur);
    base_el = restart ? '0 : st.elapsed;
    el_sum = {base_el[47], base_el} + $signed({17'b0, cfg_i.sample_period});
    if (el_sum > 49'(dur)) el_n = dur;
    else if (el_sum < 0) el_n = '0;
    else el_n = el_sum[47:0];
    // a negative duration still clamps elapsed time at zero
    if (el_n < 0) el_n = '0;
    d53 = 53'(dur);
    dur17 = (d53 <<< 4) + d53;
    thr = 49'(dur) - 49'(dur17 >>> 24);
    nr_prod = in_q.noise_level * in_q.range;
    gs_prod = 49'(in_q.gauss_sample) * $signed({17'b0, cfg_i.noise_scale});
    st_prod = 61'(nr_q) * 61'(gs_q);
    sum46 = 46'(out1_q) + 46'(step_q);
    if (sum46 > 46'sd2147483647) v1 = 32'sh7fff_ffff;
    else if (sum46 < -46'sd2147483648) v1 = 32'sh8000_0000;
    else v1 = sum46[31:0];
    diff = 34'(in_q.range) + 34'(in_q.offset) - 34'(v1_q);
    r2 = {r_q[46:0], dl_q[34]};
    ge = r2 >= rem_q;
    q = (ovf_q || quot_q > DRIFT_CAP) ? DRIFT_CAP : quot_q;
    if (active_q) vfin = neg_q ? 37'(v1_q) - 37'({2'b0, q}) : 37'(v1_q) + 37'({2'b0, q});
    else vfin = 37'(in_q.range) + 37'(in_q.offset);
    if (vfin > 37'sd2147483647) vsat = 32'sh7fff_ffff;
    else if (vfin < -37'sd2147483648) vsat = 32'sh8000_0000;
    else vsat = vfin[31:0];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        in_q  <= in_i;
        idx_q <= idx_tbl[in_i.channel];
      end
      OP_READ: rd_q <= mem_q[idx_q];
      OP_PREP: begin
        trig_q   <= new_trig;
        el_q     <= el_n;
        rem_q    <= 48'(dur - el_n);
        out1_q   <= restart ? in_q.offset : st.out_value;
        active_q <= (dur > 0) && (49'(el_n) < thr);
        nr_q     <= nr_prod[63:32];
      end
      OP_GS:   gs_q <= gs_prod[48:20];
      OP_STEP: step_q <= st_prod[60:16];
      OP_DIFF: begin
        v1_q  <= v1;
        neg_q <= 1'b0;
        mag_q <= 34'(diff);
      end
      OP_MULH: begin
        neg_q <= diff[33];
        mag_q <= diff[33] ? 34'(-diff) : 34'(diff);
      end
      OP_MULL: begin
        ph_q <= mag_q[33:16] * cfg_i.sample_period;
      end
      OP_DIVI: begin
        p_q <= {ph_q, 16'b0} + 66'(mag_q[15:0] * cfg_i.sample_period);
      end
      OP_DIV: begin
        // load the partial remainder and dividend bits once the product is ready
        if (div_init_q) begin
          r_q    <= {17'b0, p_q[65:35]};
          dl_q   <= p_q[34:0];
          quot_q <= '0;
        end else begin
          r_q    <= ge ? r2 - rem_q : r2;
          quot_q <= {quot_q[QUOT_W-2:0], ge};
          dl_q   <= {dl_q[33:0], 1'b0};
        end
      end
      OP_FIN: begin
        mem_q[idx_q] <= '{out_value: vsat, elapsed: el_q, dur: in_q.duration, trig: trig_q};
        out_q <= '{channel_out: in_q.channel, signal: vsat};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      div_init_q  <= 1'b0;
    end else begin
      div_init_q <= (cmd_i.op == OP_DIVI);
      if (cmd_i.op == OP_READ) rdv_q <= vld_q[idx_q];
      if (cmd_i.op == OP_FIN) vld_q[idx_q] <= 1'b1;
      if (cmd_i.op == OP_FIN) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (div_init_q) begin
        ovf_q <= {17'b0, p_q[65:35]} >= rem_q;
        cnt_q <= 6'(QUOT_W);
      end else if (cmd_i.op == OP_DIV) begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  assign stat_o.active   = active_q;
  assign stat_o.div_last = (cnt_q == 6'd1) && !div_init_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_o           = out_q;

endmodule

// ===== rtl/brownian_bridge_generator.sv =====
// Top level of the per-channel Brownian bridge generator.
//
// Input channel: in_valid_i / in_stall_o carry one tick for one channel
// (trigger, range, offset, noise, duration, Gaussian sample). A beat is
// taken when valid is high and stall is low. Output channel: out_valid_o /
// out_stall_i carry the channel number and its new Q8.24 output.
// Configuration: cfg_valid_i / cfg_ready_o write sample period, noise
// scale and the two trigger thresholds by index; writes are always taken.
// One tick is handled at a time. An endpoint tick goes from accept to
// result through read, prep and finish only; a tick inside the transition
// also runs the noise and drift steps, the drift from the 35-step restoring divider.
// A result sits in the output register while the next tick is taken;
// if the receiver stalls, the block holds its finished result and the
// following tick waits in its last step.
// Reset restores the default registers and marks every channel's state
// as zero through per-channel valid bits; no clearing pass is needed.
module brownian_bridge_generator import bbg_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  bbg_in_t     in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output bbg_out_t    out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  bbg_cfg_t  cfg_q;
  bbg_cmd_t  cmd;
  bbg_stat_t stat;
  logic      busy;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{PERIOD_RST, NSCALE_RST, THIGH_RST, TLOW_RST};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_data_i;
        CFG_NOISE_SCALE:   cfg_q.noise_scale   <= cfg_data_i;
        CFG_TRIGGER_HIGH:  cfg_q.trigger_high  <= cfg_data_i;
        CFG_TRIGGER_LOW:   cfg_q.trigger_low   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bbg_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .busy_o (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bbg_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .cfg_i  (cfg_q),
    .in_i,
    .out_valid_o,
    .out_stall_i,
    .out_o
  );

endmodule

// ===== rtl/bbg_checker.sv =====
// Port-level checks for the Brownian bridge generator, bound to the top level.
module bbg_checker import bbg_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input bbg_out_t out_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("not busy after accept");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o)) else $error("result too early");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o) else $error("result while still busy");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_o)))
    else $error("stalled result changed");

endmodule

bind brownian_bridge_generator bbg_checker u_bbg_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_stall_o,
  .out_valid_o,
  .out_stall_i,
  .out_o
);

// ===== sim/tb_brownian_bridge_generator.sv =====
// Self-checking testbench for the Brownian bridge generator: directed and random ticks against a local model.
module tb_brownian_bridge_generator;
  import bbg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 16;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  bbg_in_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bbg_out_t out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  brownian_bridge_generator dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // local copy of block state and registers
  logic [31:0] m_period, m_nscale;
  logic signed [31:0] m_thigh, m_tlow;
  logic signed [31:0] v_out [NCH];
  logic signed [47:0] v_elapsed [NCH];
  logic signed [47:0] v_dur [NCH];
  logic v_trig [NCH];

  bbg_in_t tick_q[$];
  bbg_out_t signal_q[$];
  int errors = 0;
  int n_sent = 0, n_got = 0, n_restart = 0, n_transit = 0;
  logic pause_tx = 1'b0;
  // input beat taken at the last rising edge
  logic taken = 1'b0;

  function automatic longint floor_div_pow2(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint drift_of(longint diff, longint per, longint rem);
    longint unsigned mag, hi, lo, p1, q1, r1, t, q;
    mag = diff < 0 ? -diff : diff;
    hi = mag >> 16;
    lo = mag & 64'hFFFF;
    p1 = hi * per;
    q1 = p1 / rem;
    r1 = p1 % rem;
    if (q1 >= (64'd1 << 18)) q = 64'd1 << 34;
    else begin
      t = (r1 << 16) + lo * per;
      q = (q1 << 16) + t / rem;
      if (q > (64'd1 << 34)) q = 64'd1 << 34;
    end
    return diff < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic bbg_out_t advance_channel(bbg_in_t t);
    int c;
    logic rising;
    longint trig, rng, ofs, noise, dur, gauss, el, v, nr, gs, stp, v1, diff;
    bbg_out_t r;
    c = t.channel % NCH;
    rising = 1'b0;
    trig = t.trigger_level; rng = t.range; ofs = t.offset;
    noise = t.noise_level; dur = t.duration; gauss = t.gauss_sample;
    if (v_trig[c]) begin
      if (trig <= longint'(m_tlow)) v_trig[c] = 1'b0;
    end else if (trig >= longint'(m_thigh)) begin
      v_trig[c] = 1'b1;
      rising = 1'b1;
    end
    if (rising || dur != longint'(v_dur[c])) begin
      v_elapsed[c] = '0;
      v_out[c] = t.offset;
      v_dur[c] = t.duration;
      n_restart++;
    end
    el = longint'(v_elapsed[c]) + longint'({32'd0, m_period});
    if (el > dur) el = dur;
    if (el < 0) el = 0;
    v_elapsed[c] = el[47:0];
    if (dur > 0 && el < dur - floor_div_pow2(dur * 17, 24)) begin
      nr = floor_div_pow2(noise * rng, 32);
      gs = floor_div_pow2(gauss * longint'({32'd0, m_nscale}), 20);
      stp = floor_div_pow2(nr * gs, 16);
      v1 = clamp32(longint'(v_out[c]) + stp);
      diff = rng + ofs - v1;
      v = v1 + drift_of(diff, longint'({32'd0, m_period}), dur - el);
      n_transit++;
    end else v = rng + ofs;
    v_out[c] = 32'(clamp32(v));
    r.channel_out = t.channel;
    r.signal = v_out[c];
    return r;
  endfunction

  // driver: bursts with random gaps
  int burst = 0, gap = 0;
  always @(negedge clk_i) begin
    // hold a waiting beat until it is taken
    if (!in_valid_i || taken) begin
      if (gap > 0) begin
        gap--;
        in_valid_i <= 1'b0;
      end else if (tick_q.size() > 0 && !pause_tx && rst_ni) begin
        in_valid_i <= 1'b1;
        in_i <= tick_q[0];
        if (burst == 0) burst = $urandom_range(1, 30);
        burst--;
        if (burst == 0) gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      end else in_valid_i <= 1'b0;
    end
  end

  // receiver stall pattern: phases of none, light and heavy stall
  int stall_mode = 0, stall_len = 0;
  always @(negedge clk_i) begin
    if (stall_len == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_len = $urandom_range(20, 400);
    end
    stall_len--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    taken = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid_i && !in_stall_o) begin
        signal_q.push_back(advance_channel(tick_q.pop_front()));
        n_sent++;
        idle_cycles = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        n_got++;
        if (signal_q.size() == 0) begin
          $error("unexpected result channel_out=%0d signal=%0d", out_o.channel_out, out_o.signal);
          errors++;
        end else begin
          bbg_out_t e;
          e = signal_q.pop_front();
          if (e.channel_out !== out_o.channel_out) begin
            $error("channel_out expected %0d actual %0d", e.channel_out, out_o.channel_out);
            errors++;
          end
          if (e.signal !== out_o.signal) begin
            $error("signal expected %0d actual %0d", e.signal, out_o.signal);
            errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) idle_cycles = 0;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_SAMPLE_PERIOD: m_period = val;
      CFG_NOISE_SCALE: m_nscale = val;
      CFG_TRIGGER_HIGH: m_thigh = val;
      CFG_TRIGGER_LOW: m_tlow = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (tick_q.size() > 0 || signal_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_volt();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h0A00_0000)) - 32'sh0500_0000;
    endcase
  endfunction

  function automatic logic signed [47:0] rand_dur(logic signed [47:0] cur);
    case ($urandom_range(0, 19))
      0: return 48'({$urandom(), $urandom()});
      1: return -48'sd1 * $urandom_range(0, 1000);
      2: return 48'sh7FFF_FFFF_FFFF;
      3: return 48'sh8000_0000_0000;
      4: return 48'sd0;
      5, 6: return 48'($urandom_range(1, 4000));
      default: return cur;
    endcase
  endfunction

  // random ticks on random channels: random content, mostly steady durations
  logic signed [47:0] cur_dur [NCH];
  task automatic queue_random(int n);
    bbg_in_t t;
    int c;
    repeat (n) begin
      c = $urandom_range(0, NCH - 1);
      t.channel = 4'(c);
      t.trigger_level = ($urandom_range(0, 9) == 0) ? rand_volt()
                        : $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0080_0000;
      t.range = rand_volt();
      t.offset = rand_volt();
      t.noise_level = rand_volt();
      cur_dur[c] = rand_dur(cur_dur[c]);
      t.duration = cur_dur[c];
      t.gauss_sample = 16'($urandom());
      tick_q.push_back(t);
    end
  endtask

  function automatic bbg_in_t mk(int c, logic signed [31:0] tr, logic signed [31:0] rg,
                                 logic signed [31:0] of, logic signed [31:0] nz,
                                 logic signed [47:0] du, logic signed [15:0] g);
    bbg_in_t t;
    t.channel = 4'(c); t.trigger_level = tr; t.range = rg; t.offset = of;
    t.noise_level = nz; t.duration = du; t.gauss_sample = g;
    return t;
  endfunction

  initial begin
    m_period = PERIOD_RST; m_nscale = NSCALE_RST;
    m_thigh = THIGH_RST; m_tlow = TLOW_RST;
    for (int i = 0; i < NCH; i++) begin
      v_out[i] = '0; v_elapsed[i] = '0; v_dur[i] = '0; v_trig[i] = 1'b0;
      cur_dur[i] = 48'sd1000000;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, restarts, endpoints, Schmitt edges
    write_reg(CFG_SAMPLE_PERIOD, 32'd1 << 20);
    tick_q.push_back(mk(0, 32'sh0200_0000, 32'sh0100_0000, 0, 32'sh0100_0000, 48'sd1 << 32,
                        16'sh7FFF));
    tick_q.push_back(mk(0, 0, 32'sh0100_0000, 0, 32'sh0100_0000, 48'sd1 << 32, 16'sh8000));
    tick_q.push_back(mk(0, 0, 32'sh0100_0000, 0, 32'sh0100_0000, 48'sd1 << 32, 16'sh0000));
    tick_q.push_back(mk(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        48'sh7FFF_FFFF_FFFF, 16'sh7FFF));
    tick_q.push_back(mk(1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        48'sh7FFF_FFFF_FFFF, 16'sh8000));
    tick_q.push_back(mk(2, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 48'sd5, 16'sh7FFF));
    tick_q.push_back(mk(3, 0, 32'sh0300_0000, 32'sh0100_0000, 0, 48'sd0, 0));
    tick_q.push_back(mk(3, 0, 32'sh0300_0000, 32'sh0100_0000, 0, -48'sd7, 0));
    tick_q.push_back(mk(4, 0, 32'sh0100_0000, 0, 0, 48'sh8000_0000_0000, 0));
    tick_q.push_back(mk(5, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 48'sd3 << 20, 0));
    tick_q.push_back(mk(5, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 48'sd3 << 20, 0));
    tick_q.push_back(mk(5, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 48'sd3 << 20, 0));
    tick_q.push_back(mk(15, 32'sh0100_0000, 32'sh0100_0000, 0, 0, 48'sd1 << 30, 0));
    tick_q.push_back(mk(15, 32'sh00FF_FFFF, 32'sh0100_0000, 0, 0, 48'sd1 << 30, 0));
    tick_q.push_back(mk(15, 0, 32'sh0100_0000, 0, 0, 48'sd1 << 30, 0));
    tick_q.push_back(mk(15, 32'sh0100_0000, 32'sh0100_0000, 0, 0, 48'sd1 << 30, 0));
    drain();

    // hold sender mid-stream until every result is back
    queue_random(40);
    repeat (300) @(posedge clk_i);
    pause_tx = 1'b1;
    while (signal_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    pause_tx = 1'b0;
    drain();

    // phases across register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_SAMPLE_PERIOD, PERIOD_RST); write_reg(CFG_NOISE_SCALE, NSCALE_RST);
          write_reg(CFG_TRIGGER_HIGH, THIGH_RST); write_reg(CFG_TRIGGER_LOW, TLOW_RST);
        end
        1: begin
          write_reg(CFG_SAMPLE_PERIOD, 32'hFFFF_FFFF); write_reg(CFG_NOISE_SCALE, 32'hFFFF_FFFF);
          write_reg(CFG_TRIGGER_HIGH, 32'h7FFF_FFFF); write_reg(CFG_TRIGGER_LOW, 32'h8000_0000);
        end
        2: begin
          write_reg(CFG_SAMPLE_PERIOD, 32'd0); write_reg(CFG_NOISE_SCALE, 32'd0);
          write_reg(CFG_TRIGGER_HIGH, 32'h8000_0000); write_reg(CFG_TRIGGER_LOW, 32'h7FFF_FFFF);
        end
        3: begin
          write_reg(CFG_SAMPLE_PERIOD, 32'd1); write_reg(CFG_NOISE_SCALE, 32'd1);
          write_reg(CFG_TRIGGER_HIGH, 32'h0000_0000); write_reg(CFG_TRIGGER_LOW, 32'h0080_0000);
        end
        default: begin
          write_reg(CFG_SAMPLE_PERIOD, $urandom_range(1, 32'h0100_0000));
          write_reg(CFG_NOISE_SCALE, $urandom());
          write_reg(CFG_TRIGGER_HIGH, $urandom_range(0, 32'h0180_0000));
          write_reg(CFG_TRIGGER_LOW, $urandom_range(0, 32'h0080_0000));
        end
      endcase
      queue_random(ph < 4 ? 150 : 350);
      drain();
    end

    $display("ticks sent %0d, results checked %0d, restarts %0d, in-transition steps %0d",
             n_sent, n_got, n_restart, n_transit);
    $display("six register settings plus directed extremes; sender and receiver idled at random");
    if (errors == 0 && signal_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== brownian_bridge_generator.f =====
rtl/bbg_pkg.sv
rtl/bbg_ctrl.sv
rtl/bbg_dp.sv
rtl/brownian_bridge_generator.sv
rtl/bbg_checker.sv
sim/tb_brownian_bridge_generator.sv
